// ===== sv/lpht_pkg.sv =====
package lpht_pkg;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_USED    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef struct packed {
      mark_type    mark;
      logic [31:0] key;
      logic [31:0] value;
   } slot_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MIX,
      S_MUL,
      S_MOD,
      S_REM,
      S_PROBE
   } state_type;

   localparam logic [31:0] HASH_MULT  = 32'd2654435761;
   localparam logic [1:0]  ROUND_LAST = 2'd3;

   // One round of the integer mix: a shift-add followed by a shift-xor.
   function automatic logic [31:0] mix_round(input logic [31:0] k, input logic [1:0] round);
      logic [31:0] a;
      logic [31:0] r;
      a = k;
      r = k;
      case (round)
         2'd0: begin
            a = k + (k << 12);
            r = a ^ (a >> 22);
         end
         2'd1: begin
            a = k + (k << 4);
            r = a ^ (a >> 9);
         end
         2'd2: begin
            a = k + (k << 10);
            r = a ^ (a >> 2);
         end
         2'd3: begin
            a = k + (k << 7);
            r = a ^ (a >> 12);
         end
         default: begin
            r = k;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== sv/linear_probe_hash_table.sv =====
// Put, get and remove: accept, the mix rounds and a multiply, then the home slot is taken (with
// an extra remainder step for a depth that is not a power of two), then 1 to TABLE_DEPTH slots are
// probed in turn through the single read port of the slot memory before the result registers.
// Read by index: accept plus one slot read. One item is in flight at a time; the next
// transaction is taken in the cycle after a result is registered, even if it is not yet taken.
// Reset is synchronous; afterwards a clearing pass empties every slot.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // key_in[31:0], value_in[63:32], slot_index[73:64], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // value_out[31:0], key_out[63:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int WIDE_W = IDX_W + 11;
   localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);
   localparam logic [31:0]      DEPTH_W32 = 32'(TABLE_DEPTH);
   localparam logic [31:0]      RECIP     = 32'((64'd1 << 32) / TABLE_DEPTH);

   slot_type slot_mem [TABLE_DEPTH];
   slot_type rd_slot_ff;
   slot_type wr_slot;
   logic     wr_en;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] probe_addr_ff, probe_addr_in;
   logic [IDX_W-1:0] steps_ff, steps_in;
   logic [IDX_W:0]   count_ff, count_in;
   logic [31:0]      mix_ff, mix_in;
   logic [1:0]       round_ff, round_in;
   logic [31:0]      quot_ff, quot_in;
   op_type           op_ff, op_in;
   logic [31:0]      req_key_ff, req_key_in;
   logic [31:0]      req_value_ff, req_value_in;
   logic             idx_ok_ff, idx_ok_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_value_ff, rsp_value_in;
   logic [31:0]      rsp_key_ff, rsp_key_in;

   logic [31:0]      prod;
   logic [63:0]      quot_prod;
   logic [31:0]      rem_wide;
   logic [IDX_W:0]   rem_t;
   logic [IDX_W-1:0] next_addr;
   logic             out_free;
   logic             done;
   logic             table_full;
   logic             key_hit;
   logic             last_step;
   status_type       res_status;

   assign prod       = (mix_ff >> 3) * HASH_MULT;
   assign quot_prod  = {32'd0, mix_ff} * {32'd0, RECIP};
   assign rem_wide   = mix_ff - (quot_ff * DEPTH_W32);
   assign next_addr  = (probe_addr_ff == LAST_ADDR) ? '0 : probe_addr_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign table_full = (count_ff == DEPTH_EXT);
   assign key_hit    = (rd_slot_ff.mark == MARK_USED) && (rd_slot_ff.key == req_key_ff);
   assign last_step  = (steps_ff == LAST_ADDR);

   // quotient estimate is low by at most one, so one subtract finishes the remainder
   always_comb begin
      rem_t = rem_wide[IDX_W:0];
      if (rem_t >= DEPTH_EXT) begin
         rem_t = rem_t - DEPTH_EXT;
      end
   end

   // Slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[probe_addr_ff] <= wr_slot;
      end
      rd_slot_ff <= slot_mem[probe_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         probe_addr_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         probe_addr_ff <= probe_addr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      mix_ff        <= mix_in;
      round_ff      <= round_in;
      quot_ff       <= quot_in;
      op_ff         <= op_in;
      req_key_ff    <= req_key_in;
      req_value_ff  <= req_value_in;
      idx_ok_ff     <= idx_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_key_ff    <= rsp_key_in;
   end

   always_comb begin
      state_in      = state_ff;
      probe_addr_in = probe_addr_ff;
      steps_in      = steps_ff;
      count_in      = count_ff;
      mix_in        = mix_ff;
      round_in      = round_ff;
      quot_in       = quot_ff;
      op_in         = op_ff;
      req_key_in    = req_key_ff;
      req_value_in  = req_value_ff;
      idx_ok_in     = idx_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_key_in    = rsp_key_ff;
      wr_en         = 1'b0;
      wr_slot       = rd_slot_ff;
      done          = 1'b0;
      res_status    = ST_MISSING;
      req_tready    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_slot = '{mark: MARK_EMPTY, key: '0, value: '0};
            if (probe_addr_ff == LAST_ADDR) begin
               probe_addr_in = '0;
               state_in      = S_IDLE;
            end else begin
               probe_addr_in = probe_addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in        = op_type'(req_tuser);
               req_key_in   = req_tdata[31:0];
               req_value_in = req_tdata[63:32];
               idx_ok_in    = (WIDE_W'(req_tdata[73:64]) < WIDE_W'(TABLE_DEPTH));
               mix_in       = req_tdata[31:0];
               round_in     = '0;
               steps_in     = '0;
               if (op_type'(req_tuser) == OP_READ) begin
                  probe_addr_in = IDX_W'(req_tdata[73:64]);
                  state_in      = S_PROBE;
               end else begin
                  state_in = S_MIX;
               end
            end
         end

         S_MIX: begin
            mix_in   = mix_round(mix_ff, round_ff);
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            mix_in   = prod;
            state_in = S_MOD;
         end

         S_MOD: begin
            if (IS_POW2) begin
               probe_addr_in = mix_ff[IDX_W-1:0];
               state_in      = S_PROBE;
            end else begin
               // estimate the quotient by the reciprocal, take the remainder next cycle
               quot_in  = quot_prod[63:32];
               state_in = S_REM;
            end
         end

         S_REM: begin
            probe_addr_in = rem_t[IDX_W-1:0];
            state_in      = S_PROBE;
         end

         S_PROBE: begin
            case (op_ff)
               OP_READ: begin
                  done = 1'b1;
                  if (idx_ok_ff && rd_slot_ff.mark == MARK_USED) begin
                     res_status = ST_OK;
                  end
               end
               OP_PUT: begin
                  if (table_full) begin
                     done       = 1'b1;
                     res_status = ST_FULL;
                  end else if (rd_slot_ff.mark != MARK_USED) begin
                     done       = 1'b1;
                     res_status = ST_OK;
                  end else if (last_step) begin
                     done       = 1'b1;
                     res_status = ST_FULL;
                  end
               end
               default: begin
                  if (key_hit) begin
                     done       = 1'b1;
                     res_status = ST_OK;
                  end else if (rd_slot_ff.mark == MARK_EMPTY || last_step) begin
                     done       = 1'b1;
                     res_status = ST_MISSING;
                  end
               end
            endcase

            if (!done) begin
               probe_addr_in = next_addr;
               steps_in      = steps_ff + 1'b1;
            end else if (out_free) begin
               // hold the probe address while the result register is occupied
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status;
               rsp_value_in  = '0;
               rsp_key_in    = '0;
               state_in      = S_IDLE;
               if (res_status == ST_OK) begin
                  case (op_ff)
                     OP_PUT: begin
                        wr_en    = 1'b1;
                        wr_slot  = '{mark: MARK_USED, key: req_key_ff, value: req_value_ff};
                        count_in = count_ff + 1'b1;
                     end
                     OP_GET: begin
                        rsp_value_in = rd_slot_ff.value;
                     end
                     OP_REMOVE: begin
                        wr_en        = 1'b1;
                        wr_slot.mark = MARK_DELETED;
                        count_in     = count_ff - 1'b1;
                     end
                     default: begin
                        rsp_value_in = rd_slot_ff.value;
                        rsp_key_in   = rd_slot_ff.key;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_key_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_EXT)
      else $error("entry count above table depth");

   // a successful put adds exactly one entry
   a_put_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && wr_en && op_ff == OP_PUT) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("put did not add one entry");

   // no transaction taken while the clearing pass runs
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready)
      else $error("request accepted during clear");

   // failed requests return zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0 && rsp_key_ff == '0))
      else $error("nonzero payload on failed request");

   // the result register only loads when a request is finishing
   a_load_from_probe: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && $past(state_ff) != S_PROBE) |-> !$past(rsp_valid_in) || reset)
      else $error("result loaded outside probe");

endmodule

// ===== verif/linear_probe_hash_table_tb.sv =====
`timescale 1ns / 1ps

module linear_probe_hash_table_tb
   import lpht_pkg::*;
();

   localparam int DEPTH       = 1024;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int POOL_SIZE   = 24;

   typedef struct {
      status_type  status;
      logic [31:0] value;
      logic [31:0] key;
   } table_reply_type;

   class hash_table_scoreboard;
      mark_type        marks [DEPTH];
      logic [31:0]     keys  [DEPTH];
      logic [31:0]     vals  [DEPTH];
      int              entries;
      int              mismatches;
      table_reply_type pending_replies[$];

      function new();
         foreach (marks[i]) begin
            marks[i] = MARK_EMPTY;
            keys[i]  = '0;
            vals[i]  = '0;
         end
         entries    = 0;
         mismatches = 0;
      endfunction

      // Integer mix, then multiplicative hash of the mixed key shifted right by 3.
      function int home_of(logic [31:0] k);
         logic [31:0] h;
         h = k;
         h = h + (h << 12);
         h = h ^ (h >> 22);
         h = h + (h << 4);
         h = h ^ (h >> 9);
         h = h + (h << 10);
         h = h ^ (h >> 2);
         h = h + (h << 7);
         h = h ^ (h >> 12);
         h = (h >> 3) * 32'd2654435761;
         return int'(h % DEPTH);
      endfunction

      // Skip deleted slots, stop at an empty one, visit each slot once.
      function int find_slot(logic [31:0] k);
         int s;
         s = home_of(k);
         for (int n = 0; n < DEPTH; n++) begin
            if (marks[s] == MARK_USED && keys[s] == k) return s;
            if (marks[s] == MARK_EMPTY) return -1;
            s = (s + 1) % DEPTH;
         end
         return -1;
      endfunction

      function logic [31:0] pick_stored_key();
         int i;
         for (int t = 0; t < 16; t++) begin
            i = $urandom_range(0, DEPTH - 1);
            if (marks[i] == MARK_USED) return keys[i];
         end
         return $urandom;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void note_request(op_type op, logic [31:0] k, logic [31:0] v,
                                 logic [9:0] idx);
         table_reply_type r;
         int              s;
         r.status = ST_MISSING;
         r.value  = '0;
         r.key    = '0;
         case (op)
            OP_PUT: begin
               if (entries < DEPTH) begin
                  s = home_of(k);
                  while (marks[s] == MARK_USED) s = (s + 1) % DEPTH;
                  marks[s] = MARK_USED;
                  keys[s]  = k;
                  vals[s]  = v;
                  entries++;
                  r.status = ST_OK;
               end else begin
                  r.status = ST_FULL;
               end
            end
            OP_GET: begin
               s = find_slot(k);
               if (s >= 0) begin
                  r.status = ST_OK;
                  r.value  = vals[s];
               end
            end
            OP_REMOVE: begin
               s = find_slot(k);
               if (s >= 0) begin
                  marks[s] = MARK_DELETED;
                  keys[s]  = '0;
                  vals[s]  = '0;
                  entries--;
                  r.status = ST_OK;
               end
            end
            default: begin
               if (idx < DEPTH && marks[idx] == MARK_USED) begin
                  r.status = ST_OK;
                  r.key    = keys[idx];
                  r.value  = vals[idx];
               end
            end
         endcase
         pending_replies.push_back(r);
      endfunction

      function void check_result(logic [1:0] st, logic [31:0] v, logic [31:0] k);
         table_reply_type want;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: status %0d value %h key %h", st, v, k);
            return;
         end
         want = pending_replies.pop_front();
         if (st !== want.status || v !== want.value || k !== want.key) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: status exp %0d got %0d, value exp %h got %h, key exp %h got %h",
                        want.status, st, want.value, v, want.key, k);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;   // key_in[31:0], value_in[63:32], slot_index[73:64], zero pad
   logic [1:0]  req_tuser  = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // value_out[31:0], key_out[63:32]
   logic [1:0]  rsp_tuser;         // status[1:0]

   hash_table_scoreboard table_sb;
   logic [31:0] key_pool[POOL_SIZE];
   int          cycle_count = 0;
   int          send_calm   = 0;
   int          rsp_hold    = 0;
   int          rsp_calm    = 0;

   linear_probe_hash_table #(.TABLE_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver stalls: mostly ready, short and long holds, and calm stretches.
   always @(posedge clock) begin
      int r;
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm   <= rsp_calm - 1;
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
         end else if (r < 88) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(0, 3);
         end else if (r < 95) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(10, 40);
         end else begin
            rsp_tready <= 1'b1;
            rsp_calm   <= $urandom_range(30, 150);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         table_sb.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
   end

   task automatic sender_gap();
      int r;
      int gap;
      gap = 0;
      if (send_calm > 0) begin
         send_calm--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50)      gap = 0;
         else if (r < 80) gap = $urandom_range(1, 3);
         else if (r < 93) gap = $urandom_range(4, 12);
         else if (r < 97) gap = $urandom_range(20, 60);
         else             send_calm = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the transaction until accepted, then record it; valid stays up for the next one.
   task automatic issue(input op_type op, input logic [31:0] k, input logic [31:0] v,
                        input logic [9:0] idx);
      sender_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, idx, v, k};
      do @(posedge clock); while (req_tready !== 1'b1);
      table_sb.note_request(op, k, v, idx);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (table_sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return table_sb.pick_stored_key();
      if (r < 75) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic send_mixed(input int w_put, input int w_get, input int w_remove);
      int     r;
      op_type op;
      r = $urandom_range(0, 99);
      if (r < w_put)                         op = OP_PUT;
      else if (r < w_put + w_get)            op = OP_GET;
      else if (r < w_put + w_get + w_remove) op = OP_REMOVE;
      else                                   op = OP_READ;
      issue(op, pick_key(), $urandom, 10'($urandom_range(0, DEPTH - 1)));
   endtask

   initial begin
      logic [9:0] home_zero;
      logic [9:0] home_ones;
      table_sb = new();
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      key_pool[4] = 32'h0000_0001;
      for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      home_zero = 10'(table_sb.home_of(32'h0000_0000));
      home_ones = 10'(table_sb.home_of(32'hFFFF_FFFF));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table, extremes, duplicates and probing past deleted slots.
      issue(OP_READ,   32'h0,         32'h0,         10'd0);
      issue(OP_READ,   32'h0,         32'h0,         10'd1023);
      issue(OP_GET,    32'h0,         32'h0,         10'd0);
      issue(OP_REMOVE, 32'hFFFF_FFFF, 32'h0,         10'd0);
      issue(OP_PUT,    32'h0,         32'h0,         10'd0);
      issue(OP_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
      issue(OP_PUT,    32'h0,         32'h1234_5678, 10'd0);
      issue(OP_GET,    32'h0,         32'h0,         10'd0);
      issue(OP_READ,   32'h0,         32'h0,         home_zero);
      issue(OP_READ,   32'h0,         32'h0,         home_ones);
      issue(OP_REMOVE, 32'h0,         32'h0,         10'd0);
      issue(OP_READ,   32'h0,         32'h0,         home_zero);
      issue(OP_GET,    32'h0,         32'h0,         10'd0);
      issue(OP_REMOVE, 32'h0,         32'h0,         10'd0);
      issue(OP_GET,    32'h0,         32'h0,         10'd0);
      issue(OP_PUT,    32'h0,         32'hAAAA_5555, 10'h2AA);
      issue(OP_READ,   32'h0,         32'h0,         home_zero);
      issue(OP_GET,    32'hFFFF_FFFF, 32'h0,         10'h155);
      issue(OP_PUT,    32'h8000_0001, 32'h5555_AAAA, 10'h155);
      issue(OP_READ,   32'h0,         32'h0,         10'h2AA);
      issue(OP_READ,   32'h0,         32'h0,         10'h155);

      for (int i = 0; i < 150; i++) send_mixed(45, 25, 15);

      // Let every result come back before loading the table.
      drain();

      while (table_sb.entries < DEPTH) begin
         if ($urandom_range(0, 9) == 0)
            issue(OP_PUT, key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom,
                  10'($urandom_range(0, DEPTH - 1)));
         else
            issue(OP_PUT, $urandom, $urandom, 10'($urandom_range(0, DEPTH - 1)));
      end

      // Full table: refused puts, whole-table probes, then a freed slot taken again.
      issue(OP_PUT,    $urandom,                  $urandom, 10'd0);
      issue(OP_PUT,    32'hFFFF_FFFF,             $urandom, 10'h3FF);
      issue(OP_GET,    $urandom,                  32'h0,    10'd0);
      issue(OP_GET,    table_sb.pick_stored_key(), 32'h0,   10'd0);
      issue(OP_READ,   32'h0,                     32'h0,    10'($urandom_range(0, DEPTH - 1)));
      issue(OP_REMOVE, table_sb.pick_stored_key(), 32'h0,   10'd0);
      issue(OP_PUT,    $urandom,                  $urandom, 10'd0);
      issue(OP_PUT,    $urandom,                  $urandom, 10'd0);
      issue(OP_REMOVE, $urandom,                  32'h0,    10'd0);

      for (int i = 0; i < 100; i++) send_mixed(25, 30, 25);

      drain();
      repeat (20) @(posedge clock);
      if (table_sb.mismatches == 0 && table_sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
